// ----- sv/assert_macros.svh -----
// Assertion macros shared by the evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rpn_pkg.sv -----
// Shared types and constants of the RPN stack evaluator.
package rpn_pkg;

	localparam int WordW = 32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_UNDERFLOW = 3'd1,
		ERR_OVERFLOW  = 3'd2,
		ERR_DIVZERO   = 3'd3,
		ERR_BADOP     = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POPB,
		ST_POPA,
		ST_EXEC,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [WordW-1:0] dividend;
		logic [WordW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WordW-1:0] quot;
	} div_rsp_t;

endpackage

// ----- sv/rpn_stack_mem.sv -----
// Stack word memory: one write port, one read port, registered read data.
module rpn_stack_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [rpn_pkg::WordW-1:0]  wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [rpn_pkg::WordW-1:0]  rdata
);

	logic [rpn_pkg::WordW-1:0] mem [DEPTH];
	logic [rpn_pkg::WordW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/rpn_div.sv -----
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`include "assert_macros.svh"

module rpn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::div_req_t req,
	output rpn_pkg::div_rsp_t rsp
);

	localparam int W  = rpn_pkg::WordW;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          fix_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  q_q;
	logic          neg_q;

	logic [W:0]    trial;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
	assign ge    = !trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
			den_q <= req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
			rem_q <= '0;
			neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
			quo_q <= {quo_q[W-2:0], ge};
		end else if (fix_q) begin
			q_q <= neg_q ? (W'(0) - quo_q) : quo_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;

	`AST_CHK(a_div_start_idle, req.start |-> !busy_q && !fix_q, "divider started while busy")
	`AST_NEXT(a_div_done_pulse, done_q, !done_q && !busy_q, "divider done not a single pulse")

endmodule

// ----- sv/rpn_digit_stack_evaluator_unit.sv -----
// Top level of the RPN stack evaluator: sequencer, stack pointer and result register.
//
// Input channel: char_code with in_valid/in_ready, one character per beat.
// Digits push their value; + - * / pop two words and push the result; any other
// character pops two words and flags a bad operator; NUL or newline pops the top
// and sends one result beat (value, status, depth_left) on out_valid/out_ready.
// Digits push on accept; operators step POPB, POPA, EXEC, and '/' then waits in DIV on
// the one-bit-per-cycle divider; end of line waits in EMIT for the result register.
// All stack words live in one memory with a registered read; the sequencer does a
// single access per cycle, so a read never overlaps a write to the same entry.
// The result register decouples the output: a character is taken while a result
// waits, and only a second end of line stalls (in_ready low) until it is taken.
// Reset empties the stack, clears the line status and drops any pending result;
// stack words are not cleared and are never read before they are pushed.
`include "assert_macros.svh"

module rpn_digit_stack_evaluator_unit #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value,
	output logic [2:0]         status,
	output logic [4:0]         depth_left
);

	localparam int W  = rpn_pkg::WordW;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int PW = $clog2(STACK_DEPTH + 1);

	rpn_pkg::state_t  state_q, state_d;
	rpn_pkg::err_t    line_err_q;
	rpn_pkg::err_t    status_q;
	rpn_pkg::div_req_t div_req;
	rpn_pkg::div_rsp_t div_rsp;

	logic [PW-1:0] sp_q, sp_d, sp_dec;
	logic          pop_empty_q, pop_empty_d;
	logic [7:0]    op_q;
	logic [W-1:0]  a_q, b_q;
	logic          out_valid_q;
	logic [W-1:0]  value_q;
	logic [4:0]    depth_q;

	logic          accept;
	logic          is_eol, is_digit;
	logic [7:0]    digit_off;
	logic          push_req, pop_req;
	logic [W-1:0]  push_val;
	logic          op_err;
	rpn_pkg::err_t op_err_code;
	logic          sp_full, sp_zero;
	logic          mem_we, mem_re;
	logic [W-1:0]  rd_data;
	logic          err_set;
	rpn_pkg::err_t err_code;
	logic          emit_go;
	logic [W-1:0]  pop_word;
	logic [31:0]   sp_ext;

	assign accept    = in_valid && in_ready;
	assign is_eol    = (char_code == rpn_pkg::CH_NUL) || (char_code == rpn_pkg::CH_LF);
	assign is_digit  = (char_code >= rpn_pkg::CH_0) && (char_code <= rpn_pkg::CH_9);
	assign digit_off = char_code - rpn_pkg::CH_0;
	assign emit_go   = !out_valid_q || out_ready;
	assign pop_word  = pop_empty_q ? '0 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		push_req    = 1'b0;
		push_val    = '0;
		pop_req     = 1'b0;
		op_err      = 1'b0;
		op_err_code = rpn_pkg::ERR_NONE;
		div_req     = '0;
		case (state_q)
			rpn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (is_eol) begin
						pop_req = 1'b1;
						state_d = rpn_pkg::ST_EMIT;
					end else if (is_digit) begin
						push_req = 1'b1;
						push_val = W'(digit_off[3:0]);
					end else begin
						pop_req = 1'b1;
						state_d = rpn_pkg::ST_POPB;
					end
				end
			end
			rpn_pkg::ST_POPB: begin
				pop_req = 1'b1;
				state_d = rpn_pkg::ST_POPA;
			end
			rpn_pkg::ST_POPA: begin
				state_d = rpn_pkg::ST_EXEC;
			end
			rpn_pkg::ST_EXEC: begin
				state_d = rpn_pkg::ST_IDLE;
				case (op_q)
					rpn_pkg::CH_PLUS: begin
						push_req = 1'b1;
						push_val = a_q + b_q;
					end
					rpn_pkg::CH_MINUS: begin
						push_req = 1'b1;
						push_val = a_q - b_q;
					end
					rpn_pkg::CH_STAR: begin
						push_req = 1'b1;
						push_val = a_q * b_q;
					end
					rpn_pkg::CH_SLASH: begin
						if (b_q == '0) begin
							op_err      = 1'b1;
							op_err_code = rpn_pkg::ERR_DIVZERO;
							push_req    = 1'b1;
						end else begin
							div_req.start    = 1'b1;
							div_req.dividend = a_q;
							div_req.divisor  = b_q;
							state_d          = rpn_pkg::ST_DIV;
						end
					end
					default: begin
						op_err      = 1'b1;
						op_err_code = rpn_pkg::ERR_BADOP;
					end
				endcase
			end
			rpn_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					push_req = 1'b1;
					push_val = div_rsp.quot;
					state_d  = rpn_pkg::ST_IDLE;
				end
			end
			rpn_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = rpn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpn_pkg::ST_IDLE;
			end
		endcase
	end

	// resolve stack accesses against the pointer
	assign sp_full = (sp_q == PW'(STACK_DEPTH));
	assign sp_zero = (sp_q == '0);
	assign sp_dec  = sp_q - PW'(1);
	assign mem_we  = push_req && !sp_full;
	assign mem_re  = pop_req && !sp_zero;

	always_comb begin
		sp_d        = sp_q;
		pop_empty_d = pop_empty_q;
		if (mem_we) begin
			sp_d = sp_q + PW'(1);
		end else if (pop_req) begin
			pop_empty_d = sp_zero;
			if (!sp_zero) begin
				sp_d = sp_dec;
			end
		end
	end

	// first error in model order wins when several land in one cycle
	always_comb begin
		err_set  = 1'b1;
		err_code = rpn_pkg::ERR_NONE;
		if (op_err) begin
			err_code = op_err_code;
		end else if (push_req && sp_full) begin
			err_code = rpn_pkg::ERR_OVERFLOW;
		end else if (pop_req && sp_zero) begin
			err_code = rpn_pkg::ERR_UNDERFLOW;
		end else begin
			err_set = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			pop_empty_q <= 1'b0;
			line_err_q  <= rpn_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			sp_q        <= sp_d;
			pop_empty_q <= pop_empty_d;
			if (state_q == rpn_pkg::ST_EMIT && emit_go) begin
				line_err_q  <= rpn_pkg::ERR_NONE;
				out_valid_q <= 1'b1;
			end else begin
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (err_set && line_err_q == rpn_pkg::ERR_NONE) begin
					line_err_q <= err_code;
				end
			end
		end
	end

	assign sp_ext = 32'(sp_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= char_code;
		end
		if (state_q == rpn_pkg::ST_POPB) begin
			b_q <= pop_word;
		end
		if (state_q == rpn_pkg::ST_POPA) begin
			a_q <= pop_word;
		end
		if (state_q == rpn_pkg::ST_EMIT && emit_go) begin
			value_q  <= pop_word;
			status_q <= line_err_q;
			depth_q  <= (sp_ext > 32'd31) ? 5'd31 : sp_ext[4:0];
		end
	end

	rpn_stack_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(sp_q[AW-1:0]),
		.wdata(push_val),
		.re   (mem_re),
		.raddr(sp_dec[AW-1:0]),
		.rdata(rd_data)
	);

	rpn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign status     = status_q;
	assign depth_left = depth_q;

	`AST_CHK(a_sp_range, sp_q <= PW'(STACK_DEPTH), "stack pointer beyond depth")
	`AST_CHK(a_div_done_state, div_rsp.done |-> state_q == rpn_pkg::ST_DIV,
		"divider result outside divide wait")
	`AST_NEXT(a_emit_clears_err, state_q == rpn_pkg::ST_EMIT && emit_go,
		line_err_q == rpn_pkg::ERR_NONE && out_valid_q, "line status not cleared on emit")
	`AST_CHK(a_one_access, !(mem_we && mem_re), "stack read and write in one cycle")

endmodule

// ----- dv/rpn_digit_stack_evaluator_unit_tb.sv -----
// Self-checking testbench for the RPN digit stack evaluator: stimulus, expression predictor, checks.
module rpn_digit_stack_evaluator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 16;
	localparam int RANDOM_CHARS = 900;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [7:0] code;
		bit         drain_first;
	} char_beat_t;

	typedef struct packed {
		logic signed [31:0] value;
		rpn_pkg::err_t      status;
		logic [4:0]         depth_left;
	} line_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         char_code = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b1;
	logic signed [31:0] value;
	logic [2:0]         status;
	logic [4:0]         depth_left;

	char_beat_t   char_q[$];
	line_result_t pending_results[$];
	char_beat_t   next_beat;
	bit           hold_next = 1'b0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           rdy_run = 0;
	int           mismatches = 0;
	int           cycle_count = 0;

	// Evaluator state as predicted from accepted characters
	logic [31:0]   eval_stack [STACK_DEPTH];
	int            eval_sp = 0;
	rpn_pkg::err_t line_err = rpn_pkg::ERR_NONE;

	rpn_digit_stack_evaluator_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.status    (status),
		.depth_left(depth_left)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void note_err(rpn_pkg::err_t code);
		if (line_err == rpn_pkg::ERR_NONE)
			line_err = code;
	endfunction

	function automatic void push_word(logic [31:0] word);
		if (eval_sp >= STACK_DEPTH) begin
			note_err(rpn_pkg::ERR_OVERFLOW);
		end else begin
			eval_stack[eval_sp] = word;
			eval_sp++;
		end
	endfunction

	function automatic logic [31:0] pop_word();
		if (eval_sp == 0) begin
			note_err(rpn_pkg::ERR_UNDERFLOW);
			return '0;
		end
		eval_sp--;
		return eval_stack[eval_sp];
	endfunction

	function automatic logic [31:0] div_toward_zero(logic [31:0] num, logic [31:0] den);
		logic [31:0] mag_n;
		logic [31:0] mag_d;
		logic [31:0] quot;
		mag_n = num[31] ? -num : num;
		mag_d = den[31] ? -den : den;
		if (mag_d == '0) begin
			note_err(rpn_pkg::ERR_DIVZERO);
			return '0;
		end
		quot = mag_n / mag_d;
		return (num[31] ^ den[31]) ? -quot : quot;
	endfunction

	function automatic void eval_char(logic [7:0] ch);
		logic [31:0]  op_a;
		logic [31:0]  op_b;
		line_result_t res;
		if (ch == rpn_pkg::CH_NUL || ch == rpn_pkg::CH_LF) begin
			res.value = pop_word();
			res.status = line_err;
			res.depth_left = (eval_sp > 31) ? 5'd31 : 5'(eval_sp);
			pending_results.push_back(res);
			line_err = rpn_pkg::ERR_NONE;
		end else if (ch >= rpn_pkg::CH_0 && ch <= rpn_pkg::CH_9) begin
			push_word(32'(ch - rpn_pkg::CH_0));
		end else begin
			op_b = pop_word();
			op_a = pop_word();
			case (ch)
				rpn_pkg::CH_PLUS:  push_word(op_a + op_b);
				rpn_pkg::CH_MINUS: push_word(op_a - op_b);
				rpn_pkg::CH_STAR:  push_word(op_a * op_b);
				rpn_pkg::CH_SLASH: push_word(div_toward_zero(op_a, op_b));
				default:           note_err(rpn_pkg::ERR_BADOP);
			endcase
		end
	endfunction

	function automatic void add_char(logic [7:0] ch);
		char_beat_t beat;
		beat.code = ch;
		beat.drain_first = hold_next;
		hold_next = 1'b0;
		char_q.push_back(beat);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function automatic logic [7:0] rand_digit(int lo, int hi);
		return rpn_pkg::CH_0 + 8'($urandom_range(hi, lo));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0:       return rpn_pkg::CH_PLUS;
			1:       return rpn_pkg::CH_MINUS;
			2:       return rpn_pkg::CH_STAR;
			default: return rpn_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] rand_bad_op();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(1, 255));
		while ((ch >= rpn_pkg::CH_0 && ch <= rpn_pkg::CH_9) || ch == rpn_pkg::CH_LF ||
			ch == rpn_pkg::CH_PLUS || ch == rpn_pkg::CH_MINUS ||
			ch == rpn_pkg::CH_STAR || ch == rpn_pkg::CH_SLASH);
		return ch;
	endfunction

	function automatic void add_end_of_line();
		add_char($urandom_range(0, 3) == 0 ? rpn_pkg::CH_NUL : rpn_pkg::CH_LF);
	endfunction

	// Well-formed expression of up to six digits, now and then with a stray operator
	function automatic void add_expression();
		int pend;
		int held;
		pend = $urandom_range(1, 6);
		held = 0;
		while (pend > 0 || held > 1) begin
			if (pend > 0 && (held < 2 || $urandom_range(0, 1) == 1)) begin
				add_char(rand_digit(0, 9));
				pend--;
				held++;
			end else begin
				add_char(rand_op());
				held--;
			end
			if ($urandom_range(0, 24) == 0)
				add_char(rand_bad_op());
		end
		add_end_of_line();
	endfunction

	function automatic void add_operand(bit neg, int lo);
		if (neg) begin
			add_char(rpn_pkg::CH_0);
			add_char(rand_digit(lo, 9));
			add_char(rpn_pkg::CH_MINUS);
		end else begin
			add_char(rand_digit(lo, 9));
		end
	endfunction

	function automatic void add_drain_line();
		repeat (9) add_char(rand_bad_op());
		add_char(rpn_pkg::CH_LF);
	endfunction

	function automatic void add_random_line();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			hold_next = 1'b1;
		if (kind < 58) begin
			add_expression();
		end else if (kind < 74) begin
			n = $urandom_range(1, 12);
			repeat (n) add_char(8'($urandom_range(0, 255)));
			add_char(rpn_pkg::CH_LF);
		end else if (kind < 81) begin
			// Overflow first, then the bad operators drain the stack
			n = $urandom_range(17, 20);
			repeat (n) add_char(rand_digit(0, 9));
			repeat (10) add_char(rand_bad_op());
			add_end_of_line();
		end else if (kind < 87) begin
			// 2 * 8^10 wraps to the most negative word, then divide by a negative digit
			add_drain_line();
			add_char(rpn_pkg::CH_0 + 8'd2);
			repeat (10) add_char(rpn_pkg::CH_0 + 8'd8);
			repeat (10) add_char(rpn_pkg::CH_STAR);
			add_operand(1'b1, 1);
			add_char(rpn_pkg::CH_SLASH);
			add_end_of_line();
		end else if (kind < 93) begin
			n = $urandom_range(9, 13);
			repeat (n) add_char(rand_digit(5, 9));
			repeat (n - 1)
				add_char($urandom_range(0, 4) == 0 ? rpn_pkg::CH_MINUS : rpn_pkg::CH_STAR);
			add_end_of_line();
		end else begin
			add_operand($urandom_range(0, 1) == 1, 0);
			add_operand($urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0 ? 0 : 1);
			add_char(rpn_pkg::CH_SLASH);
			add_end_of_line();
		end
	endfunction

	// Sender: bursts of beats with random gaps, holds valid until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			char_code  <= 8'h00;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				eval_char(char_code);
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (char_q.size() == 0 ||
					(char_q[0].drain_first && pending_results.size() != 0)) begin
				in_valid <= 1'b0;
			end else begin
				next_beat = char_q.pop_front();
				in_valid  <= 1'b1;
				char_code <= next_beat.code;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
						: $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0
						: ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
						: $urandom_range(1, 4);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: check each result beat, stall on runs of its own
	always @(posedge clk or negedge arst_n) begin
		line_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b1;
			rdy_run   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual value %0d status %0d depth %0d",
						$time, value, status, depth_left);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (value !== want.value) begin
						$display("%0t: value expected %0d actual %0d", $time, want.value, value);
						mismatches++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status, status);
						mismatches++;
					end
					if (depth_left !== want.depth_left) begin
						$display("%0t: depth_left expected %0d actual %0d", $time,
							want.depth_left, depth_left);
						mismatches++;
					end
				end
			end
			if (rdy_run != 0) begin
				rdy_run <= rdy_run - 1;
			end else if (out_ready) begin
				out_ready <= 1'b0;
				rdy_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
					: $urandom_range(0, 4);
			end else begin
				out_ready <= 1'b1;
				rdy_run <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
					: $urandom_range(0, 8);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rpn_digit_stack_evaluator_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int directed_n;

		// Directed lines: empty line, NUL end, all four operators, divide by zero,
		// unknown operator 0xFF, operator on an empty stack
		add_char(rpn_pkg::CH_LF);
		add_text("9");
		add_char(rpn_pkg::CH_NUL);
		add_text("95-3*5/1+\n");
		add_text("70/\n");
		add_text("12");
		add_char(8'hFF);
		add_char(rpn_pkg::CH_LF);
		add_text("+\n");
		directed_n = char_q.size();

		hold_next = 1'b1;
		while (char_q.size() < directed_n + RANDOM_CHARS)
			add_random_line();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		// Let any trailing operator finish before the verdict
		repeat (60) @(posedge clk);

		if (mismatches == 0) begin
			$display("rpn_digit_stack_evaluator_unit: match");
		end else begin
			$display("rpn_digit_stack_evaluator_unit: mismatch");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_stack_mem.sv
sv/rpn_div.sv
sv/rpn_digit_stack_evaluator_unit.sv
dv/rpn_digit_stack_evaluator_unit_tb.sv
